/* hdl/hpt_pkg.sv */
// hpt_pkg: shared types and constants for the homogeneous point transform.
// No dependencies.
`timescale 1ns / 1ps
package hpt_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_POINT = 2'd1,
        CMD_DIR   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Per-item control that travels down the pipeline
    typedef struct packed {
        logic valid;
        logic point;
        logic ovf;
    } ctl_t;

endpackage

/* hdl/hpt_lane.sv */
// hpt_lane: one matrix row times the point, floor-shifted products summed and saturated.
// Depends on hpt_pkg. Two register stages: products, then saturated sum.
`timescale 1ns / 1ps
module hpt_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               advance,
    input  logic signed [31:0] e0,
    input  logic signed [31:0] e1,
    input  logic signed [31:0] e2,
    input  logic signed [31:0] e3,
    input  logic               translate,
    input  logic signed [31:0] cx,
    input  logic signed [31:0] cy,
    input  logic signed [31:0] cz,
    output logic signed [31:0] sum,
    output logic               sat
);
    import hpt_pkg::*;

    logic signed [63:0] p0_reg, p1_reg, p2_reg;
    logic signed [31:0] t_reg;
    logic signed [63:0] s;
    logic signed [31:0] sum_reg;
    logic               sat_reg;

    // Stage 1: exact products
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p0_reg <= 64'(e0) * 64'(cx);
            p1_reg <= 64'(e1) * 64'(cy);
            p2_reg <= 64'(e2) * 64'(cz);
            t_reg  <= translate ? e3 : 32'sd0;
        end
    end

    // Arithmetic shift floors toward minus infinity; keep the full sum width
    always_comb
    begin
        s = (p0_reg >>> FRAC_BITS) + (p1_reg >>> FRAC_BITS)
          + (p2_reg >>> FRAC_BITS) + 64'(t_reg);
    end

    // Stage 2: saturate
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (s > 64'sd2147483647)
            begin
                sum_reg <= 32'sh7FFFFFFF;
                sat_reg <= 1'b1;
            end
            else if (s < -64'sd2147483648)
            begin
                sum_reg <= 32'sh80000000;
                sat_reg <= 1'b1;
            end
            else
            begin
                sum_reg <= s[31:0];
                sat_reg <= 1'b0;
            end
        end
    end

    assign sum = sum_reg;
    assign sat = sat_reg;

endmodule

/* hdl/hpt_div.sv */
// hpt_div: pipelined signed divider, (num << FRAC_BITS) / den, truncated, saturated.
// Depends on hpt_pkg. A load stage, 32+FRAC_BITS one-bit stages and a sign stage.
`timescale 1ns / 1ps
module hpt_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               advance,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic signed [31:0] quo,
    output logic               sat
);
    import hpt_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int QW = NW;

    logic [NW-1:0] n_reg [QW+1];
    logic [31:0]   d_reg [QW+1];
    logic [32:0]   r_reg [QW+1];
    logic [QW-1:0] q_reg [QW+1];
    logic          neg_reg [QW+1];
    logic signed [31:0] quo_reg;
    logic          sat_reg;

    // Load magnitudes
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            n_reg[0]   <= NW'(num[31] ? -33'(num) : 33'(num)) << FRAC_BITS;
            d_reg[0]   <= den[31] ? 32'(-33'(den)) : den;
            r_reg[0]   <= '0;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[31] ^ den[31];
        end
    end

    // Restoring steps, one quotient bit each
    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [33:0] tr;
        assign tr = {r_reg[k], n_reg[k][NW-1]} - {2'b0, d_reg[k]};
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                n_reg[k+1]   <= n_reg[k] << 1;
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                if (!tr[33])
                begin
                    r_reg[k+1] <= tr[32:0];
                    q_reg[k+1] <= {q_reg[k][QW-2:0], 1'b1};
                end
                else
                begin
                    r_reg[k+1] <= {r_reg[k][31:0], n_reg[k][NW-1]};
                    q_reg[k+1] <= {q_reg[k][QW-2:0], 1'b0};
                end
            end
        end
    end

    // Apply sign and saturate
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (neg_reg[QW])
            begin
                if (q_reg[QW] > QW'(64'd2147483648))
                begin
                    quo_reg <= 32'sh80000000;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    quo_reg <= 32'(-q_reg[QW]);
                    sat_reg <= 1'b0;
                end
            end
            else if (q_reg[QW] > QW'(64'd2147483647))
            begin
                quo_reg <= 32'sh7FFFFFFF;
                sat_reg <= 1'b1;
            end
            else
            begin
                quo_reg <= q_reg[QW][31:0];
                sat_reg <= 1'b0;
            end
        end
    end

    assign quo = quo_reg;
    assign sat = sat_reg;

endmodule

/* hdl/homogeneous_point_transform_unit.sv */
// homogeneous_point_transform_unit: top level, matrix store, four row lanes,
// three dividers and the merge / output stage. Depends on hpt_pkg, hpt_lane, hpt_div.
`timescale 1ns / 1ps
//
// Usage:
//  - Input channel (in_valid / in_stall): command, entry_index, entry_value,
//    in_x, in_y, in_z. A load writes one matrix entry and yields nothing.
//  - Output channel (out_valid / out_stall): out_x, out_y, out_z,
//    w_near_zero, overflow; one transaction per point or direction item.
//  - Config channel (cfg_valid / cfg_ready): zero_tolerance, always ready.
//  - Throughput: one item per cycle while the output is not stalled. An item passes
//    two lane stages, a tolerance stage, FRAC_BITS+34 divider stages and a merge
//    register before its result is valid. The divider pipeline depth dominates
//    the latency.
//  - The whole pipeline advances together; a stall on the output holds
//    every stage and raises in_stall while the output register is full.
//  - A load takes effect for the next item accepted after it.
//  - Reset: matrix returns to identity, zero_tolerance to 1, pipeline empty.
//
module homogeneous_point_transform_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             command,
    input  logic [3:0]             entry_index,
    input  logic signed [31:0]     entry_value,
    input  logic signed [31:0]     in_x,
    input  logic signed [31:0]     in_y,
    input  logic signed [31:0]     in_z,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [31:0]     out_x,
    output logic signed [31:0]     out_y,
    output logic signed [31:0]     out_z,
    output logic                   w_near_zero,
    output logic                   overflow,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [15:0]            zero_tolerance
);
    import hpt_pkg::*;

    localparam int DL = 32 + FRAC_BITS + 2;   // divider latency

    logic signed [31:0] mat_reg [16];
    logic [15:0]        tol_reg;
    logic               advance;
    logic               take;
    logic               xform;
    cmd_t               cmd;

    // Pipeline advances unless output is held
    assign advance   = !(out_valid && out_stall);
    assign in_stall  = !advance;
    assign cfg_ready = 1'b1;
    assign take      = in_valid && advance;
    assign cmd       = cmd_t'(command);
    assign xform     = take && (cmd == CMD_POINT || cmd == CMD_DIR);

    // Matrix store and tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                mat_reg[i] <= (i % 5 == 0) ? 32'(64'd1 << FRAC_BITS) : 32'sd0;
            tol_reg <= 16'd1;
        end
        else
        begin
            if (take && cmd == CMD_LOAD)
                mat_reg[entry_index] <= entry_value;
            if (cfg_valid)
                tol_reg <= zero_tolerance;
        end
    end

    // Row lanes
    logic signed [31:0] rs [4];
    logic               rsat [4];
    for (genvar r = 0; r < 4; r++)
    begin : g_lane
        hpt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .clk       (clk),
            .advance   (advance),
            .e0        (mat_reg[4*r]),
            .e1        (mat_reg[4*r+1]),
            .e2        (mat_reg[4*r+2]),
            .e3        (mat_reg[4*r+3]),
            .translate (cmd == CMD_POINT),
            .cx        (in_x),
            .cy        (in_y),
            .cz        (in_z),
            .sum       (rs[r]),
            .sat       (rsat[r])
        );
    end

    // Control through the lane stages
    ctl_t c1_reg, c2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
        end
        else if (advance)
        begin
            c1_reg <= '{valid: xform, point: cmd == CMD_POINT, ovf: 1'b0};
            c2_reg <= c1_reg;
        end
    end

    // Tolerance stage: decide near-zero, pick the divisor
    logic [32:0]        wmag;
    logic               near;
    logic               lane_ovf;
    ctl_t               c3_reg;
    logic               near3_reg;
    logic signed [31:0] n3_reg [3];
    logic signed [31:0] w3_reg;
    assign wmag     = rs[3][31] ? -33'(rs[3]) : 33'(rs[3]);
    assign near     = c2_reg.point && (wmag <= 33'(tol_reg));
    assign lane_ovf = rsat[0] || rsat[1] || rsat[2] || (c2_reg.point && rsat[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c3_reg <= '0;
        else if (advance)
            c3_reg <= '{valid: c2_reg.valid, point: c2_reg.point, ovf: lane_ovf};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            near3_reg <= near;
            for (int i = 0; i < 3; i++)
                n3_reg[i] <= rs[i];
            // Divisor of one keeps the divider busy harmlessly when unused
            w3_reg <= (c2_reg.point && !near) ? rs[3] : 32'sd1;
        end
    end

    // Dividers
    logic signed [31:0] q [3];
    logic               qsat [3];
    for (genvar l = 0; l < 3; l++)
    begin : g_div
        hpt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .clk     (clk),
            .advance (advance),
            .num     (n3_reg[l]),
            .den     (w3_reg),
            .quo     (q[l]),
            .sat     (qsat[l])
        );
    end

    // Delay line for bypass values and control alongside the divider
    ctl_t               cd_reg [DL];
    logic               nd_reg [DL];
    logic signed [31:0] bd_reg [DL][3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DL; k++)
                cd_reg[k] <= '0;
        end
        else if (advance)
        begin
            cd_reg[0] <= c3_reg;
            for (int k = 1; k < DL; k++)
                cd_reg[k] <= cd_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            nd_reg[0] <= near3_reg;
            bd_reg[0] <= n3_reg;
            for (int k = 1; k < DL; k++)
            begin
                nd_reg[k] <= nd_reg[k-1];
                bd_reg[k] <= bd_reg[k-1];
            end
        end
    end

    // Merge: select divided or bypass values, combine flags
    ctl_t               ce;
    logic               ne;
    logic               divide;
    assign ce     = cd_reg[DL-1];
    assign ne     = nd_reg[DL-1];
    assign divide = ce.point && !ne;

    logic               ov_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (advance)
            ov_reg <= ce.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_x       <= divide ? q[0] : bd_reg[DL-1][0];
            out_y       <= divide ? q[1] : bd_reg[DL-1][1];
            out_z       <= divide ? q[2] : bd_reg[DL-1][2];
            w_near_zero <= ce.point && ne;
            overflow    <= ce.ovf || (divide && (qsat[0] || qsat[1] || qsat[2]));
        end
    end

    assign out_valid = ov_reg;

endmodule

/* sim/tb.sv */
// tb: self-checking testbench for homogeneous_point_transform_unit.
// Drives loads, point and direction items with random idling; checks each result
// against a built-in fixed-point predictor. Depends on hpt_pkg and the RTL.
`timescale 1ns / 1ps

class xform_scoreboard;
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               nz;
        logic               ovf;
    } coord_t;

    logic signed [31:0] mat [16];
    logic [15:0]        tol;
    coord_t             pending [$];
    int                 errors;

    function new();
        reset_state();
        errors = 0;
    endfunction

    function void reset_state();
        for (int i = 0; i < 16; i++)
            mat[i] = (i % 5 == 0) ? 32'sd65536 : 32'sd0;
        tol = 16'd1;
    endfunction

    // Floor-shifted product of an entry and a coordinate
    function longint prod_floor(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> 16;
    endfunction

    function longint sat(longint v, ref logic ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function longint row_dot(int row, logic signed [31:0] c [3], bit trans, ref logic ovf);
        longint s;
        s = prod_floor(mat[row*4], c[0]) + prod_floor(mat[row*4+1], c[1])
            + prod_floor(mat[row*4+2], c[2]);
        if (trans)
            s += longint'(mat[row*4+3]);
        return sat(s, ovf);
    endfunction

    // Note an accepted input item and queue its expected result
    function void note_input(hpt_pkg::cmd_t cmd, logic [3:0] idx, logic signed [31:0] val,
                             logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz);
        logic signed [31:0] c [3];
        longint r [3];
        longint w, mag;
        coord_t e;
        logic ovf;
        logic nz;
        ovf = 1'b0;
        nz = 1'b0;
        if (cmd == hpt_pkg::CMD_LOAD) begin
            mat[idx] = val;
            return;
        end
        if (cmd == hpt_pkg::CMD_NONE)
            return;
        c[0] = px;
        c[1] = py;
        c[2] = pz;
        for (int i = 0; i < 3; i++)
            r[i] = row_dot(i, c, cmd == hpt_pkg::CMD_POINT, ovf);
        if (cmd == hpt_pkg::CMD_POINT) begin
            w = row_dot(3, c, 1'b1, ovf);
            mag = (w < 0) ? -w : w;
            if (mag <= longint'(tol))
                nz = 1'b1;
            else
                for (int i = 0; i < 3; i++)
                    r[i] = sat((r[i] * 65536) / w, ovf);
        end
        e.x = r[0][31:0];
        e.y = r[1][31:0];
        e.z = r[2][31:0];
        e.nz = nz;
        e.ovf = ovf;
        pending.push_back(e);
    endfunction

    // Compare one result with the oldest expectation
    function void check_result(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, logic nz, logic ovf);
        coord_t e;
        if (pending.size() == 0) begin
            report("unexpected result", 0, 0);
            return;
        end
        e = pending.pop_front();
        if (x !== e.x) report("out_x", x, e.x);
        if (y !== e.y) report("out_y", y, e.y);
        if (z !== e.z) report("out_z", z, e.z);
        if (nz !== e.nz) report("w_near_zero", nz, e.nz);
        if (ovf !== e.ovf) report("overflow", ovf, e.ovf);
    endfunction

    function void report(string what, longint got, longint want);
        errors++;
        if (errors <= 50)
            $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    endfunction
endclass

module tb;
    import hpt_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         command = CMD_NONE;
    logic [3:0]         entry_index = '0;
    logic signed [31:0] entry_value = '0;
    logic signed [31:0] in_x = '0;
    logic signed [31:0] in_y = '0;
    logic signed [31:0] in_z = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               w_near_zero;
    logic               overflow;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [15:0]        zero_tolerance = 16'd1;

    localparam int LATENCY = 53;
    localparam int WATCHDOG = 4000;

    xform_scoreboard sb = new();
    bit  calm;
    int  idle_cycles = 0;

    always #5 clk = ~clk;

    homogeneous_point_transform_unit u_dut (.*);

    // Check results and count cycles without any transaction
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                sb.check_result(out_x, out_y, out_z, w_near_zero, overflow);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Stall the output in random bursts
    initial begin
        int n;
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 8);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    function logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        endcase
    endfunction

    // Present one item and hold it until accepted
    task automatic send_item(cmd_t cmd, logic [3:0] idx, logic [31:0] val,
                             logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        int n;
        if (!calm && $urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        entry_index <= idx;
        entry_value <= val;
        in_x <= px;
        in_y <= py;
        in_z <= pz;
        do @(posedge clk); while (in_stall);
        sb.note_input(cmd, idx, val, px, py, pz);
        @(negedge clk);
    endtask

    // Drain all results, then write the tolerance register
    task automatic set_tolerance(logic [15:0] t);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (LATENCY) @(negedge clk);
        cfg_valid <= 1'b1;
        zero_tolerance <= t;
        do @(posedge clk); while (!cfg_ready);
        sb.tol = t;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_random_matrix();
        for (int i = 0; i < 16; i++)
            send_item(CMD_LOAD, i[3:0],
                      ($urandom_range(0, 3) == 0) ? rnd_coord()
                      : $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000,
                      $urandom, $urandom, $urandom);
    endtask

    task automatic random_item();
        int k;
        k = $urandom_range(0, 19);
        if (k < 2)
            send_item(CMD_LOAD, 4'($urandom), rnd_coord(), $urandom, $urandom, $urandom);
        else if (k < 3)
            send_item(CMD_NONE, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
        else if (k < 4)
            // force a small w by loading a small value into one bottom-row entry
            send_item(CMD_LOAD, 4'd12 + 4'($urandom_range(0, 3)), $urandom_range(0, 3) - 1,
                      0, 0, 0);
        else
            send_item((k < 14) ? CMD_POINT : CMD_DIR, 4'($urandom), $urandom,
                      rnd_coord(), rnd_coord(), rnd_coord());
    endtask

    initial begin
        calm = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: identity, extremes, zero w, direction, unused command
        send_item(CMD_POINT, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
        send_item(CMD_DIR, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_item(CMD_NONE, 4'hF, 32'hFFFF_FFFF, 1, 2, 3);
        send_item(CMD_LOAD, 4'd15, 0, 0, 0, 0);
        send_item(CMD_POINT, 0, 0, 32'h0003_0000, 5, 6);
        send_item(CMD_LOAD, 4'd15, 1, 0, 0, 0);
        send_item(CMD_POINT, 0, 0, 7, 8, 9);
        send_item(CMD_LOAD, 4'd15, 2, 0, 0, 0);
        send_item(CMD_POINT, 0, 0, 32'h0001_0000, 0, 0);
        send_item(CMD_LOAD, 4'd3, 32'h7FFF_FFFF, 0, 0, 0);
        send_item(CMD_LOAD, 4'd15, 32'hFFFF_FFF0, 0, 0, 0);
        send_item(CMD_POINT, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(CMD_LOAD, 4'd0, 32'h8000_0000, 0, 0, 0);
        send_item(CMD_DIR, 0, 0, 32'h8000_0000, 1, 1);
        send_item(CMD_POINT, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        set_tolerance(16'hFFFF);
        send_item(CMD_LOAD, 4'd15, 32'h0000_FFFF, 0, 0, 0);
        send_item(CMD_POINT, 0, 0, 32'h0001_0000, 3, 3);
        send_item(CMD_LOAD, 4'd15, 32'h0001_0000, 0, 0, 0);
        send_item(CMD_POINT, 0, 0, 32'h0001_0000, 3, 3);
        set_tolerance(16'h0000);
        send_item(CMD_LOAD, 4'd15, 0, 0, 0, 0);
        send_item(CMD_POINT, 0, 0, 32'h0001_0000, 3, 3);

        // Random phases over several tolerance settings
        for (int ph = 0; ph < 6; ph++) begin
            set_tolerance((ph == 0) ? 16'd0 : (ph == 1) ? 16'hFFFF : 16'($urandom));
            if (ph == 5)
                calm = 1;
            load_random_matrix();
            repeat (260) random_item();
        end

        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (LATENCY) @(negedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

/* sim.f */
hdl/hpt_pkg.sv
hdl/hpt_lane.sv
hdl/hpt_div.sv
hdl/homogeneous_point_transform_unit.sv
sim/tb.sv
